>>> rtl/pawe_pkg.sv
// ----------------------------------------------------------------------------
// pawe_pkg
// Shared types and constants for the partition allocator with eviction.
// ----------------------------------------------------------------------------
package pawe_pkg;

    localparam int MAX_PART   = 32;
    localparam int IDX_W      = $clog2(MAX_PART);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 17;
    localparam int LEN_W      = 17;
    localparam int NEED_W     = 18;
    localparam int STAMP_W    = 16;
    localparam int ID_W       = 32;
    localparam int OPC_W      = 8;
    localparam int EVC_W      = 6;
    localparam int PER_W      = 7;
    localparam int BASE_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOROOM   = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCHEME, REG_FIT, REG_VICTIM, REG_MINP, REG_MEMSZ, REG_PERIOD, REG_BASE
    } cfg_reg_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_TOUCH_STEP, OP_FIT_STEP, OP_SELECT, OP_SPLIT, OP_ALLOC,
        OP_SCAN_INIT, OP_VICT_STEP, OP_NOROOM, OP_FREE, OP_MERGE_R, OP_MERGE_L,
        OP_BUDDY, OP_COUNT, OP_COMP_INIT, OP_COMP_STEP, OP_COMP_END, OP_OUT_LOAD
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_TOUCH, S_FIT, S_PLACE, S_SPLIT, S_ALLOC, S_VICT, S_FREE,
        S_MR, S_ML, S_MB, S_EVDONE, S_CCHK, S_COMP, S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic             init_busy;
        logic             req_touch;
        logic             buddy;
        logic             scan_end;
        logic             hit;
        logic             pick_any;
        logic             split_ok;
        logic             vict_found;
        logic             buddy_ok;
        logic             comp_due;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } dp_sts_t;

endpackage

>>> rtl/partition_allocator_with_eviction.sv
// ----------------------------------------------------------------------------
// partition_allocator_with_eviction
// Partition table allocator with first/best fit, buddy mode and eviction.
// ----------------------------------------------------------------------------
// One item is worked on at a time; a finished result waits in the output
// register while the next item is taken. All table work runs through one
// sequencer that visits one table entry per cycle. A touch scans the table
// until it hits or reaches the end. An allocate runs a fit scan, then
// places the item, with one extra step per buddy halving. Every eviction
// adds a victim scan, a free, two merge steps and a rescan in dynamic mode;
// in buddy mode one merge step per buddy merge takes the place of the two
// merge steps. A compaction adds another scan over the table. A write to
// the scheme, memory size or base register rebuilds the table, and no item
// is taken while it does.
// ----------------------------------------------------------------------------
module partition_allocator_with_eviction (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [pawe_pkg::LEN_W-1:0]         msg_size,
    input  logic [pawe_pkg::ID_W-1:0]          msg_id,
    input  logic [pawe_pkg::OPC_W-1:0]         op_code,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic [pawe_pkg::ADDR_W-1:0]        start_pos,
    output logic [pawe_pkg::LEN_W-1:0]         part_size,
    output logic [pawe_pkg::EVC_W-1:0]         evicted_count,
    output logic                               compacted,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pawe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pawe_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pawe_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    pawe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pawe_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_type      (req_type),
        .msg_size      (msg_size),
        .msg_id        (msg_id),
        .op_code       (op_code),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .start_pos     (start_pos),
        .part_size     (part_size),
        .evicted_count (evicted_count),
        .compacted     (compacted)
    );

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sts.count != '0) && (sts.count <= CNT_W'(MAX_PART)))
        else $error("partition count out of range");

    a_done_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_DONE)) |-> (part_size != '0))
        else $error("completed item reports an empty partition");

    a_touch_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_NOTFOUND)) |-> ((evicted_count == '0) && !compacted))
        else $error("touch miss reports eviction work");

endmodule

>>> rtl/pawe_ctrl.sv
// ----------------------------------------------------------------------------
// pawe_ctrl
// Sequencer: walks the scan, split, evict, merge and compaction steps.
// ----------------------------------------------------------------------------
module pawe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pawe_pkg::dp_sts_t sts,
    output pawe_pkg::dp_cmd_t cmd
);
    import pawe_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = !sts.init_busy;
                if (in_valid && !sts.init_busy)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = sts.req_touch ? S_TOUCH : S_FIT;
            end
            S_TOUCH:
            begin
                cmd.op = OP_TOUCH_STEP;
                if (sts.scan_end || sts.hit)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FIT:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    cmd.op = OP_FIT_STEP;
                end
            end
            S_PLACE:
            begin
                if (sts.pick_any)
                begin
                    cmd.op     = OP_SELECT;
                    state_next = S_SPLIT;
                end
                else
                begin
                    cmd.op     = OP_SCAN_INIT;
                    state_next = S_VICT;
                end
            end
            S_SPLIT:
            begin
                if (sts.split_ok)
                begin
                    cmd.op = OP_SPLIT;
                    // buddy blocks keep halving
                    if (!sts.buddy)
                    begin
                        state_next = S_ALLOC;
                    end
                end
                else
                begin
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                cmd.op     = OP_ALLOC;
                state_next = S_FINISH;
            end
            S_VICT:
            begin
                if (sts.scan_end)
                begin
                    if (sts.vict_found)
                    begin
                        state_next = S_FREE;
                    end
                    else
                    begin
                        cmd.op     = OP_NOROOM;
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    cmd.op = OP_VICT_STEP;
                end
            end
            S_FREE:
            begin
                cmd.op     = OP_FREE;
                state_next = sts.buddy ? S_MB : S_MR;
            end
            S_MR:
            begin
                cmd.op     = OP_MERGE_R;
                state_next = S_ML;
            end
            S_ML:
            begin
                cmd.op     = OP_MERGE_L;
                state_next = S_EVDONE;
            end
            S_MB:
            begin
                if (sts.buddy_ok)
                begin
                    cmd.op = OP_BUDDY;
                end
                else
                begin
                    state_next = S_EVDONE;
                end
            end
            S_EVDONE:
            begin
                cmd.op     = OP_COUNT;
                state_next = S_CCHK;
            end
            S_CCHK:
            begin
                if (sts.comp_due)
                begin
                    cmd.op     = OP_COMP_INIT;
                    state_next = S_COMP;
                end
                else
                begin
                    cmd.op     = OP_SCAN_INIT;
                    state_next = S_FIT;
                end
            end
            S_COMP:
            begin
                if (sts.scan_end)
                begin
                    cmd.op     = OP_COMP_END;
                    state_next = S_FIT;
                end
                else
                begin
                    cmd.op = OP_COMP_STEP;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/pawe_dp.sv
// ----------------------------------------------------------------------------
// pawe_dp
// Datapath: partition table, configuration, scan registers and result item.
// ----------------------------------------------------------------------------
module pawe_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pawe_pkg::dp_cmd_t                  cmd,
    output pawe_pkg::dp_sts_t                  sts,
    input  logic                               req_type,
    input  logic [pawe_pkg::LEN_W-1:0]         msg_size,
    input  logic [pawe_pkg::ID_W-1:0]          msg_id,
    input  logic [pawe_pkg::OPC_W-1:0]         op_code,
    input  logic                               cfg_valid,
    input  logic [pawe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pawe_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic [pawe_pkg::ADDR_W-1:0]        start_pos,
    output logic [pawe_pkg::LEN_W-1:0]         part_size,
    output logic [pawe_pkg::EVC_W-1:0]         evicted_count,
    output logic                               compacted
);
    import pawe_pkg::*;

    function automatic logic [NEED_W-1:0] ceil_pow2(input logic [NEED_W-1:0] v);
        logic [NEED_W-1:0] p;
        begin
            p = v - 1'b1;
            p = p | (p >> 1);
            p = p | (p >> 2);
            p = p | (p >> 4);
            p = p | (p >> 8);
            p = p | (p >> 16);
            ceil_pow2 = p + 1'b1;
        end
    endfunction

    function automatic logic [LEN_W-1:0] floor_pow2(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] p;
        begin
            p = v;
            p = p | (p >> 1);
            p = p | (p >> 2);
            p = p | (p >> 4);
            p = p | (p >> 8);
            p = p | (p >> 16);
            floor_pow2 = (p >> 1) + 1'b1;
        end
    endfunction

    localparam logic [LEN_W-1:0] LEN_MAX = 17'h10000;
    localparam logic [LEN_W-1:0] MEM_MIN = 17'd16;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PART);

    // configuration
    logic                  scheme_reg, fit_reg, victim_reg, init_pend_reg;
    logic [LEN_W-1:0]      minp_reg, memsz_reg;
    logic [PER_W-1:0]      period_reg;
    logic [BASE_W-1:0]     base_reg;

    // partition table
    logic [ADDR_W-1:0]     start_reg [MAX_PART];
    logic [LEN_W-1:0]      len_reg   [MAX_PART];
    logic                  used_reg  [MAX_PART];
    logic [STAMP_W-1:0]    stamp_reg [MAX_PART];
    logic [ID_W-1:0]       msg_reg   [MAX_PART];
    logic [OPC_W-1:0]      opc_reg   [MAX_PART];
    logic [CNT_W-1:0]      count_reg;
    logic [STAMP_W-1:0]    ctr_reg;

    // request and scan state
    logic                  touch_reg;
    logic [NEED_W-1:0]     need_reg;
    logic [ID_W-1:0]       id_reg;
    logic [OPC_W-1:0]      rop_reg;
    logic [CNT_W-1:0]      idx_reg, n_reg;
    logic [IDX_W-1:0]      pick_reg, exact_reg, vict_reg, cur_reg;
    logic                  pick_v_reg, exact_v_reg, vict_v_reg;
    logic [LEN_W-1:0]      bestlen_reg, freed_reg;
    logic [STAMP_W-1:0]    age_reg;
    logic [ADDR_W-1:0]     pos_reg;
    logic [EVC_W-1:0]      evc_reg;
    logic                  comp_reg;

    // result and output item
    logic [1:0]            rstat_reg, ostat_reg;
    logic [ADDR_W-1:0]     rstart_reg, ostart_reg;
    logic [LEN_W-1:0]      rsize_reg, osize_reg;
    logic [EVC_W-1:0]      oevc_reg;
    logic                  ocomp_reg, ov_reg;

    // derived values
    logic [LEN_W-1:0]      eff_min, eff_mem, mem_sat;
    logic [NEED_W-1:0]     need_raw, need_in;
    logic [IDX_W-1:0]      ix, cur_m1, cur_p1, sel, mj, si;
    logic                  scan_end, hit, fit_q, split_ok, do_split, do_merge;
    logic                  mr_ok, ml_ok, bl_side, bl_ok, br_ok, comp_due;
    logic [LEN_W-1:0]      cur_len, sl, off;
    logic [STAMP_W-1:0]    age;

    always_comb
    begin
        eff_min = (minp_reg == '0) ? LEN_W'(1) : ((minp_reg > LEN_MAX) ? LEN_MAX : minp_reg);
        mem_sat = (memsz_reg < MEM_MIN) ? MEM_MIN
                : ((memsz_reg > LEN_MAX) ? LEN_MAX : memsz_reg);
        eff_mem = scheme_reg ? floor_pow2(mem_sat) : mem_sat;

        need_raw = (msg_size == '0) ? NEED_W'(1) : {1'b0, msg_size};
        if (need_raw < {1'b0, eff_min})
        begin
            need_raw = {1'b0, eff_min};
        end
        need_in = scheme_reg ? ceil_pow2(need_raw) : need_raw;

        ix       = idx_reg[IDX_W-1:0];
        scan_end = (idx_reg == count_reg);
        hit      = !scan_end && used_reg[ix] && (msg_reg[ix] == id_reg);
        fit_q    = !used_reg[ix] && ({1'b0, len_reg[ix]} >= need_reg)
                 && (({1'b0, len_reg[ix]} == need_reg)
                     || (({1'b0, len_reg[ix]} - need_reg) >= {1'b0, eff_min}));
        age      = ctr_reg - stamp_reg[ix];
        sel      = exact_v_reg ? exact_reg : pick_reg;

        cur_m1   = cur_reg - 1'b1;
        cur_p1   = cur_reg + 1'b1;
        cur_len  = len_reg[cur_reg];
        split_ok = (count_reg < CNT_MAX)
                 && (scheme_reg ? ({2'b0, cur_len[LEN_W-1:1]} >= need_reg)
                                : ({1'b0, cur_len} > need_reg));
        sl       = scheme_reg ? {1'b0, cur_len[LEN_W-1:1]} : need_reg[LEN_W-1:0];

        mr_ok = (({1'b0, cur_reg} + 1'b1) < count_reg) && !used_reg[cur_p1];
        ml_ok = (cur_reg != '0) && !used_reg[cur_m1];

        off     = start_reg[cur_reg] - {1'b0, base_reg};
        bl_side = |(off & cur_len);
        bl_ok   = ml_ok && (len_reg[cur_m1] == cur_len)
                && ((start_reg[cur_m1] + cur_len) == start_reg[cur_reg]);
        br_ok   = mr_ok && (len_reg[cur_p1] == cur_len)
                && (start_reg[cur_p1] == (start_reg[cur_reg] + cur_len));

        comp_due = !scheme_reg
                 && ((period_reg == '0) || (period_reg == PER_W'(1))
                     || (!period_reg[PER_W-1] && (period_reg > PER_W'(1))
                         && ({1'b0, evc_reg} == period_reg)));

        si       = cur_reg;
        do_split = (cmd.op == OP_SPLIT) && split_ok;
        mj       = cur_reg;
        do_merge = 1'b0;
        case (cmd.op)
            OP_MERGE_R:
            begin
                do_merge = mr_ok;
            end
            OP_MERGE_L:
            begin
                do_merge = ml_ok;
                mj       = cur_m1;
            end
            OP_BUDDY:
            begin
                do_merge = bl_side ? bl_ok : br_ok;
                mj       = bl_side ? cur_m1 : cur_reg;
            end
            default:
            begin
                do_merge = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scheme_reg    <= 1'b0;
            fit_reg       <= 1'b0;
            victim_reg    <= 1'b0;
            minp_reg      <= LEN_W'(32);
            memsz_reg     <= LEN_W'(4096);
            period_reg    <= '1;
            base_reg      <= '0;
            init_pend_reg <= 1'b0;
            for (int k = 0; k < MAX_PART; k++)
            begin
                start_reg[k] <= '0;
                len_reg[k]   <= '0;
                used_reg[k]  <= 1'b0;
                stamp_reg[k] <= '0;
                msg_reg[k]   <= '0;
                opc_reg[k]   <= '0;
            end
            len_reg[0]  <= LEN_W'(4096);
            count_reg   <= CNT_W'(1);
            ctr_reg     <= '0;
            touch_reg   <= 1'b0;
            need_reg    <= '0;
            id_reg      <= '0;
            rop_reg     <= '0;
            idx_reg     <= '0;
            n_reg       <= '0;
            pick_reg    <= '0;
            exact_reg   <= '0;
            vict_reg    <= '0;
            cur_reg     <= '0;
            pick_v_reg  <= 1'b0;
            exact_v_reg <= 1'b0;
            vict_v_reg  <= 1'b0;
            bestlen_reg <= '0;
            freed_reg   <= '0;
            age_reg     <= '0;
            pos_reg     <= '0;
            evc_reg     <= '0;
            comp_reg    <= 1'b0;
            rstat_reg   <= ST_DONE;
            rstart_reg  <= '0;
            rsize_reg   <= '0;
            ostat_reg   <= ST_DONE;
            ostart_reg  <= '0;
            osize_reg   <= '0;
            oevc_reg    <= '0;
            ocomp_reg   <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SCHEME:
                    begin
                        scheme_reg    <= cfg_data[0];
                        init_pend_reg <= 1'b1;
                    end
                    REG_FIT:    fit_reg    <= cfg_data[0];
                    REG_VICTIM: victim_reg <= cfg_data[0];
                    REG_MINP:   minp_reg   <= cfg_data;
                    REG_MEMSZ:
                    begin
                        memsz_reg     <= cfg_data;
                        init_pend_reg <= 1'b1;
                    end
                    REG_PERIOD: period_reg <= cfg_data[PER_W-1:0];
                    REG_BASE:
                    begin
                        base_reg      <= cfg_data[BASE_W-1:0];
                        init_pend_reg <= 1'b1;
                    end
                    default:
                    begin
                        init_pend_reg <= init_pend_reg;
                    end
                endcase
            end
            else if (init_pend_reg)
            begin
                // rebuild the table from the new settings
                init_pend_reg <= 1'b0;
                for (int k = 0; k < MAX_PART; k++)
                begin
                    used_reg[k] <= 1'b0;
                end
                start_reg[0] <= {1'b0, base_reg};
                len_reg[0]   <= eff_mem;
                count_reg    <= CNT_W'(1);
                ctr_reg      <= '0;
            end

            if (out_valid && out_ready && (cmd.op != OP_OUT_LOAD))
            begin
                ov_reg <= 1'b0;
            end

            if (do_split)
            begin
                for (int k = 1; k < MAX_PART; k++)
                begin
                    if ((CNT_W'(k) > ({1'b0, si} + 1'b1)) && (CNT_W'(k) <= count_reg))
                    begin
                        start_reg[k] <= start_reg[k-1];
                        len_reg[k]   <= len_reg[k-1];
                        used_reg[k]  <= used_reg[k-1];
                        stamp_reg[k] <= stamp_reg[k-1];
                        msg_reg[k]   <= msg_reg[k-1];
                        opc_reg[k]   <= opc_reg[k-1];
                    end
                end
                start_reg[si + 1'b1] <= start_reg[si] + sl;
                len_reg[si + 1'b1]   <= len_reg[si] - sl;
                used_reg[si + 1'b1]  <= 1'b0;
                len_reg[si]          <= sl;
                count_reg            <= count_reg + 1'b1;
            end

            if (do_merge)
            begin
                for (int k = 0; k < MAX_PART - 1; k++)
                begin
                    if ((CNT_W'(k) > {1'b0, mj}) && ((CNT_W'(k) + 1'b1) < count_reg))
                    begin
                        start_reg[k] <= start_reg[k+1];
                        len_reg[k]   <= len_reg[k+1];
                        used_reg[k]  <= used_reg[k+1];
                        stamp_reg[k] <= stamp_reg[k+1];
                        msg_reg[k]   <= msg_reg[k+1];
                        opc_reg[k]   <= opc_reg[k+1];
                    end
                end
                len_reg[mj] <= len_reg[mj] + len_reg[mj + 1'b1];
                count_reg   <= count_reg - 1'b1;
                cur_reg     <= mj;
            end

            case (cmd.op)
                OP_LOAD:
                begin
                    touch_reg   <= req_type;
                    need_reg    <= need_in;
                    id_reg      <= msg_id;
                    rop_reg     <= op_code;
                    idx_reg     <= '0;
                    pick_v_reg  <= 1'b0;
                    exact_v_reg <= 1'b0;
                    vict_v_reg  <= 1'b0;
                    evc_reg     <= '0;
                    comp_reg    <= 1'b0;
                end
                OP_TOUCH_STEP:
                begin
                    if (scan_end)
                    begin
                        rstat_reg  <= ST_NOTFOUND;
                        rstart_reg <= '0;
                        rsize_reg  <= '0;
                    end
                    else if (hit)
                    begin
                        rstat_reg  <= ST_DONE;
                        rstart_reg <= start_reg[ix];
                        rsize_reg  <= len_reg[ix];
                        if (victim_reg)
                        begin
                            stamp_reg[ix] <= ctr_reg;
                            ctr_reg       <= ctr_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                OP_FIT_STEP:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (scheme_reg)
                    begin
                        if (!used_reg[ix] && ({1'b0, len_reg[ix]} == need_reg) && !exact_v_reg)
                        begin
                            exact_reg   <= ix;
                            exact_v_reg <= 1'b1;
                        end
                        if (!used_reg[ix] && ({1'b0, len_reg[ix]} > need_reg) && !pick_v_reg)
                        begin
                            pick_reg   <= ix;
                            pick_v_reg <= 1'b1;
                        end
                    end
                    else if (fit_q && (!pick_v_reg || (fit_reg && (len_reg[ix] < bestlen_reg))))
                    begin
                        pick_reg    <= ix;
                        pick_v_reg  <= 1'b1;
                        bestlen_reg <= len_reg[ix];
                    end
                end
                OP_SELECT:
                begin
                    cur_reg <= sel;
                end
                OP_ALLOC:
                begin
                    used_reg[cur_reg]  <= 1'b1;
                    msg_reg[cur_reg]   <= id_reg;
                    opc_reg[cur_reg]   <= rop_reg;
                    stamp_reg[cur_reg] <= ctr_reg;
                    ctr_reg            <= ctr_reg + 1'b1;
                    rstat_reg          <= ST_DONE;
                    rstart_reg         <= start_reg[cur_reg];
                    rsize_reg          <= len_reg[cur_reg];
                end
                OP_SCAN_INIT:
                begin
                    idx_reg     <= '0;
                    pick_v_reg  <= 1'b0;
                    exact_v_reg <= 1'b0;
                    vict_v_reg  <= 1'b0;
                end
                OP_VICT_STEP:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (used_reg[ix] && (!vict_v_reg || (age > age_reg)))
                    begin
                        vict_reg   <= ix;
                        age_reg    <= age;
                        vict_v_reg <= 1'b1;
                    end
                end
                OP_NOROOM:
                begin
                    rstat_reg  <= ST_NOROOM;
                    rstart_reg <= '0;
                    rsize_reg  <= '0;
                end
                OP_FREE:
                begin
                    used_reg[vict_reg] <= 1'b0;
                    cur_reg            <= vict_reg;
                end
                OP_COUNT:
                begin
                    evc_reg <= evc_reg + 1'b1;
                end
                OP_COMP_INIT:
                begin
                    idx_reg   <= '0;
                    n_reg     <= '0;
                    pos_reg   <= {1'b0, base_reg};
                    freed_reg <= '0;
                    comp_reg  <= 1'b1;
                end
                OP_COMP_STEP:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (used_reg[ix])
                    begin
                        start_reg[n_reg[IDX_W-1:0]] <= pos_reg;
                        len_reg[n_reg[IDX_W-1:0]]   <= len_reg[ix];
                        used_reg[n_reg[IDX_W-1:0]]  <= 1'b1;
                        stamp_reg[n_reg[IDX_W-1:0]] <= stamp_reg[ix];
                        msg_reg[n_reg[IDX_W-1:0]]   <= msg_reg[ix];
                        opc_reg[n_reg[IDX_W-1:0]]   <= opc_reg[ix];
                        pos_reg                     <= pos_reg + len_reg[ix];
                        n_reg                       <= n_reg + 1'b1;
                    end
                    else
                    begin
                        freed_reg <= freed_reg + len_reg[ix];
                    end
                end
                OP_COMP_END:
                begin
                    // append all free space as one trailing partition
                    if ((freed_reg != '0) && (n_reg < CNT_MAX))
                    begin
                        start_reg[n_reg[IDX_W-1:0]] <= pos_reg;
                        len_reg[n_reg[IDX_W-1:0]]   <= freed_reg;
                        used_reg[n_reg[IDX_W-1:0]]  <= 1'b0;
                        count_reg                   <= n_reg + 1'b1;
                    end
                    else
                    begin
                        count_reg <= n_reg;
                    end
                    idx_reg     <= '0;
                    pick_v_reg  <= 1'b0;
                    exact_v_reg <= 1'b0;
                    vict_v_reg  <= 1'b0;
                end
                OP_OUT_LOAD:
                begin
                    ov_reg     <= 1'b1;
                    ostat_reg  <= rstat_reg;
                    ostart_reg <= rstart_reg;
                    osize_reg  <= rsize_reg;
                    oevc_reg   <= evc_reg;
                    ocomp_reg  <= comp_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        sts.init_busy  = init_pend_reg;
        sts.req_touch  = touch_reg;
        sts.buddy      = scheme_reg;
        sts.scan_end   = scan_end;
        sts.hit        = hit;
        sts.pick_any   = pick_v_reg || exact_v_reg;
        sts.split_ok   = split_ok;
        sts.vict_found = vict_v_reg;
        sts.buddy_ok   = bl_side ? bl_ok : br_ok;
        sts.comp_due   = comp_due;
        sts.out_free   = !ov_reg || out_ready;
        sts.count      = count_reg;
    end

    assign out_valid     = ov_reg;
    assign status        = ostat_reg;
    assign start_pos     = ostart_reg;
    assign part_size     = osize_reg;
    assign evicted_count = oevc_reg;
    assign compacted     = ocomp_reg;

endmodule

>>> tb/partition_allocator_with_eviction_tb.sv
// ----------------------------------------------------------------------------
// partition_allocator_with_eviction_tb
// Checks every result against an in-bench model of the partition table:
// directed corner items, then randomized allocate/touch traffic across
// dynamic and buddy schemes, fit and eviction choices, compaction periods
// and size extremes. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module partition_allocator_with_eviction_tb;

    import pawe_pkg::*;

    localparam int   NPART      = 32;
    localparam int   AMASK      = 32'h1FFFF;
    localparam int   WDOG_LIMIT = 40000;
    localparam logic REQ_ALLOC  = 1'b0;
    localparam logic REQ_TOUCH  = 1'b1;

    typedef struct packed {
        logic [1:0]        st;
        logic [ADDR_W-1:0] spos;
        logic [LEN_W-1:0]  plen;
        logic [EVC_W-1:0]  nevict;
        logic              comp;
    } alloc_res_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  req_type;
    logic [LEN_W-1:0]      msg_size;
    logic [ID_W-1:0]       msg_id;
    logic [OPC_W-1:0]      op_code;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            status;
    logic [ADDR_W-1:0]     start_pos;
    logic [LEN_W-1:0]      part_size;
    logic [EVC_W-1:0]      evicted_count;
    logic                  compacted;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    partition_allocator_with_eviction u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .msg_size(msg_size), .msg_id(msg_id), .op_code(op_code),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .start_pos(start_pos), .part_size(part_size),
        .evicted_count(evicted_count), .compacted(compacted),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // model copy of configuration and table
    logic              m_scheme, m_fit, m_victim;
    logic [16:0]       m_minp, m_mem;
    logic [6:0]        m_period;
    logic [15:0]       m_base;
    int unsigned       t_start [NPART];
    int unsigned       t_len   [NPART];
    bit                t_used  [NPART];
    int unsigned       t_stamp [NPART];
    int unsigned       t_msg   [NPART];
    int unsigned       t_op    [NPART];
    int unsigned       t_count;
    int unsigned       stamp_ctr;

    alloc_res_t        pending_res [$];
    int unsigned       known_ids [$];
    int                err_cnt;
    int unsigned       mem_now;
    bit                tx_calm, rx_calm, rx_hold;
    int                rx_gap;
    int                wdog;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $time);
        err_cnt++;
    endtask

    // ---------------- table model ----------------
    function automatic int unsigned eff_mem();
        int unsigned m, p;
        m = m_mem;
        p = 1;
        if (m < 16) m = 16;
        if (m > 65536) m = 65536;
        if (m_scheme)
        begin
            while (p * 2 <= m) p = p * 2;
            m = p;
        end
        return m;
    endfunction

    function automatic int unsigned eff_min();
        int unsigned v;
        v = m_minp;
        if (v == 0) v = 1;
        if (v > 65536) v = 65536;
        return v;
    endfunction

    function automatic void clr_entry(int unsigned i);
        t_used[i] = 0; t_stamp[i] = 0; t_msg[i] = 0; t_op[i] = 0;
    endfunction

    function automatic void tbl_init();
        for (int i = 0; i < NPART; i++)
        begin
            t_start[i] = 0; t_len[i] = 0; clr_entry(i);
        end
        t_start[0] = m_base;
        t_len[0]   = eff_mem();
        t_count    = 1;
        stamp_ctr  = 0;
    endfunction

    function automatic void cpy_entry(int unsigned d, int unsigned s);
        t_start[d] = t_start[s]; t_len[d] = t_len[s]; t_used[d] = t_used[s];
        t_stamp[d] = t_stamp[s]; t_msg[d] = t_msg[s]; t_op[d] = t_op[s];
    endfunction

    function automatic void drop_entry(int unsigned i);
        if (i >= t_count) return;
        for (int unsigned k = i; k + 1 < t_count; k++) cpy_entry(k, k + 1);
        t_count--;
    endfunction

    function automatic void split_entry(int unsigned i, int unsigned left);
        if (t_count >= NPART || i >= t_count) return;
        for (int unsigned k = t_count; k > i + 1; k--) cpy_entry(k, k - 1);
        t_count++;
        t_start[i+1] = (t_start[i] + left) & AMASK;
        t_len[i+1]   = t_len[i] - left;
        clr_entry(i + 1);
        t_len[i] = left;
    endfunction

    function automatic int find_slot(int unsigned need);
        int unsigned minp;
        int          pick;
        int unsigned len;
        minp = eff_min();
        pick = -1;
        if (!m_scheme)
        begin
            for (int unsigned i = 0; i < t_count; i++)
            begin
                len = t_len[i];
                if (t_used[i] || len < need) continue;
                if (len != need && len - need < minp) continue;
                if (pick < 0 || (m_fit && len < t_len[pick])) pick = i;
                if (!m_fit) break;
            end
            if (pick >= 0 && t_len[pick] > need) split_entry(pick, need);
            return pick;
        end
        for (int unsigned i = 0; i < t_count; i++)
            if (!t_used[i] && t_len[i] == need) return i;
        for (int unsigned i = 0; i < t_count; i++)
            if (!t_used[i] && t_len[i] > need)
            begin
                pick = i;
                break;
            end
        if (pick < 0) return -1;
        while ((t_len[pick] >> 1) >= need && t_count < NPART)
            split_entry(pick, t_len[pick] >> 1);
        return pick;
    endfunction

    function automatic void merge_free(int unsigned i);
        if (i + 1 < t_count && !t_used[i+1])
        begin
            t_len[i] += t_len[i+1];
            drop_entry(i + 1);
        end
        if (i > 0 && !t_used[i-1])
        begin
            t_len[i-1] += t_len[i];
            drop_entry(i);
        end
    endfunction

    function automatic void merge_buddies(int unsigned i);
        int unsigned s, off, j;
        forever
        begin
            s   = t_len[i];
            off = (t_start[i] - m_base) & AMASK;
            if ((off & s) != 0)
            begin
                if (i == 0) return;
                j = i - 1;
                if (t_used[j] || t_len[j] != s || ((t_start[j] + s) & AMASK) != t_start[i])
                    return;
                t_len[j] = s * 2;
                drop_entry(i);
                i = j;
            end
            else
            begin
                j = i + 1;
                if (j >= t_count || t_used[j] || t_len[j] != s ||
                    t_start[j] != ((t_start[i] + s) & AMASK))
                    return;
                t_len[i] = s * 2;
                drop_entry(j);
            end
        end
    endfunction

    function automatic bit evict_oldest();
        int unsigned oldest, oldest_age, age;
        bit          found;
        oldest = 0; oldest_age = 0; found = 0;
        for (int unsigned i = 0; i < t_count; i++)
        begin
            if (!t_used[i]) continue;
            age = (stamp_ctr - t_stamp[i]) & 16'hFFFF;
            if (!found || age > oldest_age)
            begin
                oldest = i; oldest_age = age; found = 1;
            end
        end
        if (!found) return 0;
        clr_entry(oldest);
        if (m_scheme) merge_buddies(oldest);
        else merge_free(oldest);
        return 1;
    endfunction

    function automatic void compact_tbl();
        int unsigned n, pos, freed;
        n = 0; pos = m_base; freed = 0;
        for (int unsigned i = 0; i < t_count; i++)
        begin
            if (!t_used[i])
            begin
                freed += t_len[i];
                continue;
            end
            cpy_entry(n, i);
            t_start[n] = pos;
            pos = (pos + t_len[n]) & AMASK;
            n++;
        end
        if (freed > 0 && n < NPART)
        begin
            t_start[n] = pos; t_len[n] = freed; clr_entry(n); n++;
        end
        t_count = n;
    endfunction

    function automatic void apply_cfg(cfg_reg_t r, logic [16:0] v);
        case (r)
            REG_SCHEME: begin m_scheme = v[0]; tbl_init(); end
            REG_FIT:    m_fit = v[0];
            REG_VICTIM: m_victim = v[0];
            REG_MINP:   m_minp = v;
            REG_MEMSZ:  begin m_mem = v; tbl_init(); end
            REG_PERIOD: m_period = v[6:0];
            REG_BASE:   begin m_base = v[15:0]; tbl_init(); end
            default:    ;
        endcase
    endfunction

    function automatic alloc_res_t serve_request(logic rt, logic [16:0] sz,
                                                 logic [31:0] id, logic [7:0] opc);
        alloc_res_t  r;
        int unsigned need, p, nev;
        int          per, k;
        r = '0;
        r.st = ST_NOROOM;
        per = int'($signed(m_period));
        if (rt == REQ_TOUCH)
        begin
            r.st = ST_NOTFOUND;
            for (int unsigned i = 0; i < t_count; i++)
                if (t_used[i] && t_msg[i] == id)
                begin
                    r.st = ST_DONE;
                    r.spos = ADDR_W'(t_start[i]);
                    r.plen = LEN_W'(t_len[i]);
                    if (m_victim)
                    begin
                        t_stamp[i] = stamp_ctr;
                        stamp_ctr = (stamp_ctr + 1) & 16'hFFFF;
                    end
                    break;
                end
            return r;
        end
        need = sz;
        nev = 0;
        if (need == 0) need = 1;
        if (need < eff_min()) need = eff_min();
        if (m_scheme)
        begin
            p = 1;
            while (p < need) p = p * 2;
            need = p;
        end
        forever
        begin
            k = find_slot(need);
            if (k >= 0)
            begin
                t_used[k] = 1; t_msg[k] = id; t_op[k] = opc;
                t_stamp[k] = stamp_ctr;
                stamp_ctr = (stamp_ctr + 1) & 16'hFFFF;
                r.st = ST_DONE;
                r.spos = ADDR_W'(t_start[k]);
                r.plen = LEN_W'(t_len[k]);
                break;
            end
            if (!evict_oldest()) break;
            nev++;
            if (!m_scheme && (per == 0 || per == 1 || (per > 1 && nev == per)))
            begin
                compact_tbl();
                r.comp = 1'b1;
            end
        end
        r.nevict = EVC_W'(nev);
        return r;
    endfunction

    // ---------------- receiver and checker ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                alloc_res_t want;
                if (pending_res.size() == 0)
                begin
                    report("unexpected item", status, 0);
                end
                else
                begin
                    want = pending_res.pop_front();
                    if (status !== want.st) report("status", status, want.st);
                    if (start_pos !== want.spos) report("start_pos", start_pos, want.spos);
                    if (part_size !== want.plen) report("part_size", part_size, want.plen);
                    if (evicted_count !== want.nevict)
                        report("evicted_count", evicted_count, want.nevict);
                    if (compacted !== want.comp) report("compacted", compacted, want.comp);
                end
            end
            if (rx_hold)
            begin
                out_ready <= 1'b0;
            end
            else if (out_valid && out_ready)
            begin
                if (rx_calm)
                begin
                    out_ready <= 1'b1;
                end
                else
                begin
                    rx_gap    <= $urandom_range(0, 13);
                    out_ready <= 1'b0;
                end
            end
            else if (rx_gap > 0)
            begin
                rx_gap <= rx_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog: cycles without any accepted item or configuration write
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            wdog <= 0;
        end
        else if (wdog >= WDOG_LIMIT)
        begin
            $display("partition_allocator_with_eviction_tb: errors");
            $finish;
        end
        else
        begin
            wdog <= wdog + 1;
        end
    end

    // ---------------- sender side ----------------
    task automatic send_req(input logic rt, input logic [16:0] sz,
                            input logic [31:0] id, input logic [7:0] opc);
        int gap;
        in_valid <= 1'b1;
        req_type <= rt;
        msg_size <= sz;
        msg_id   <= id;
        op_code  <= opc;
        do @(posedge clk); while (!in_ready);
        pending_res.push_back(serve_request(rt, sz, id, opc));
        if (rt == REQ_ALLOC)
        begin
            known_ids.push_back(id);
            if (known_ids.size() > 48) void'(known_ids.pop_front());
        end
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the sender until every expected item has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_res.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cfg(input logic sch, input logic fit, input logic vic,
                             input logic [16:0] minp, input logic [16:0] mem,
                             input logic [6:0] per, input logic [15:0] base);
        logic [16:0] vals [7];
        drain();
        vals = '{17'(sch), 17'(fit), 17'(vic), minp, mem, 17'(per), 17'(base)};
        for (int i = 0; i < 7; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            apply_cfg(cfg_reg_t'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
        mem_now = eff_mem();
        known_ids.delete();
    endtask

    task automatic send_random();
        int unsigned pick, sz, lim;
        logic [31:0] id;
        pick = $urandom_range(0, 99);
        lim  = (mem_now / 4 < 2) ? 2 : mem_now / 4;
        if (pick < 65)
        begin
            case ($urandom_range(0, 19))
                0:       sz = $urandom_range(0, AMASK);
                1:       sz = 0;
                2:       sz = $urandom_range(1, mem_now);
                default: sz = $urandom_range(1, lim);
            endcase
            send_req(REQ_ALLOC, sz[16:0], $urandom, 8'($urandom));
        end
        else
        begin
            if (pick < 92 && known_ids.size() > 0)
                id = known_ids[$urandom_range(0, known_ids.size() - 1)];
            else
                id = $urandom;
            send_req(REQ_TOUCH, 17'($urandom), id, 8'($urandom));
        end
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
            begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            send_random();
        end
        tx_calm = 0;
        rx_calm = 0;
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        send_req(REQ_ALLOC, 17'd0, 32'h0, 8'h00);
        send_req(REQ_ALLOC, 17'd1, 32'hFFFF_FFFF, 8'hFF);
        send_req(REQ_TOUCH, 17'h1FFFF, 32'hFFFF_FFFF, 8'h00);
        send_req(REQ_TOUCH, 17'd0, 32'h1234_5678, 8'h5A);
        send_req(REQ_ALLOC, 17'h1FFFF, 32'hA5A5_A5A5, 8'hA5);
        send_req(REQ_ALLOC, 17'd4096, 32'h0000_0010, 8'h01);
        send_req(REQ_ALLOC, 17'd31, 32'h0000_0011, 8'h02);
        send_req(REQ_ALLOC, 17'd65536, 32'h0000_0012, 8'h03);
        send_req(REQ_ALLOC, 17'd4065, 32'h0000_0013, 8'h04);
        send_req(REQ_ALLOC, 17'd2048, 32'h0000_0014, 8'h05);
        send_req(REQ_ALLOC, 17'd2048, 32'h0000_0015, 8'h06);
        send_req(REQ_TOUCH, 17'd0, 32'h0000_0014, 8'h00);
        send_req(REQ_ALLOC, 17'd100, 32'h0000_0016, 8'h07);
        send_req(REQ_TOUCH, 17'd0, 32'h0000_0014, 8'h00);
        drain();
    endtask

    // fill the table with tiny items so that splits run out of entries
    task automatic test_full_table();
        write_cfg(1'b0, 1'b0, 1'b1, 17'd1, 17'd65536, 7'h7F, 16'd100);
        for (int i = 0; i < 45; i++)
            send_req(REQ_ALLOC, 17'($urandom_range(1, 8)), 32'(i), 8'(i));
        run_random(40);
        write_cfg(1'b1, 1'b0, 1'b0, 17'd1, 17'd65536, 7'h7F, 16'hFFFF);
        for (int i = 0; i < 40; i++)
            send_req(REQ_ALLOC, 17'($urandom_range(1, 4)), 32'(i + 100), 8'(i));
        run_random(40);
        drain();
    endtask

    task automatic test_backpressure();
        write_cfg(1'b0, 1'b1, 1'b1, 17'd16, 17'd1024, 7'd0, 16'hFFFF);
        fork
        begin
            rx_hold = 1;
            repeat (500) @(posedge clk);
            rx_hold = 0;
        end
        join_none
        tx_calm = 1;
        for (int i = 0; i < 30; i++) send_random();
        tx_calm = 0;
        drain();
    endtask

    task automatic test_settings();
        write_cfg(1'b0, 1'b0, 1'b0, 17'd32, 17'd4096, 7'h7F, 16'd0);
        run_random(100);
        write_cfg(1'b0, 1'b1, 1'b1, 17'd16, 17'd1024, 7'd0, 16'hFFFF);
        run_random(100);
        write_cfg(1'b0, 1'b0, 1'b1, 17'd1, 17'd65536, 7'd3, 16'd100);
        run_random(90);
        write_cfg(1'b1, 1'b0, 1'b0, 17'd16, 17'd4096, 7'd1, 16'd0);
        run_random(100);
        write_cfg(1'b1, 1'b1, 1'b1, 17'd0, 17'd1000, 7'h7F, 16'h0123);
        run_random(100);
        write_cfg(1'b0, 1'b0, 1'b0, 17'h1FFFF, 17'h1FFFF, 7'd32, 16'h8000);
        run_random(40);
        write_cfg(1'b0, 1'b1, 1'b0, 17'd1, 17'd0, 7'd1, 16'hFFFF);
        run_random(70);
        write_cfg(1'b0, 1'b1, 1'b1, 17'd8, 17'd2000, 7'h40, 16'h8000);
        run_random(100);
        write_cfg(1'b1, 1'b0, 1'b1, 17'd65536, 17'd65536, 7'd2, 16'd7);
        run_random(30);
        write_cfg(1'b0, 1'b0, 1'b1, 17'd4, 17'd512, 7'd2, 16'd0);
        run_random(100);
        drain();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = 1'b0;
        msg_size  = '0;
        msg_id    = '0;
        op_code   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_SCHEME;
        cfg_data  = '0;
        err_cnt   = 0;
        tx_calm   = 0;
        rx_calm   = 0;
        rx_hold   = 0;
        m_scheme  = 0; m_fit = 0; m_victim = 0;
        m_minp    = 17'd32; m_mem = 17'd4096; m_period = 7'h7F; m_base = 16'd0;
        tbl_init();
        mem_now   = eff_mem();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_full_table();
        test_settings();

        if (err_cnt == 0)
            $display("partition_allocator_with_eviction_tb: clean");
        else
            $display("partition_allocator_with_eviction_tb: errors");
        $finish;
    end

endmodule

>>> sim.f
rtl/pawe_pkg.sv
rtl/pawe_ctrl.sv
rtl/pawe_dp.sv
rtl/partition_allocator_with_eviction.sv
tb/partition_allocator_with_eviction_tb.sv
